// ===== rtl/ise_pkg.sv =====
// Shared types and constants for the IID test statistics engine.
// No dependencies; every module of the block imports it.
`default_nettype none

package ise_pkg;

  localparam int SymW      = 8;
  localparam int MeanW     = 24;
  localparam int MedW      = 9;
  localparam int MaskW     = 18;
  localparam int CntW      = 21;
  localparam int SumW      = 29;
  localparam int ExcW      = 45;
  localparam int CovW      = 37;
  localparam int StatW     = 48;
  localparam int IdxW      = 5;
  localparam int NumStats  = 19;
  localparam int NumLags   = 5;
  localparam int MaxLag    = 32;
  localparam int LagW      = 5;
  localparam int MaxSamples = 1048576;

  localparam int LagTab [NumLags] = '{1, 2, 8, 16, 32};

  // Result indexes
  localparam logic [IdxW-1:0] StExcursion = 5'd0;
  localparam logic [IdxW-1:0] StDirRuns   = 5'd1;
  localparam logic [IdxW-1:0] StDirMax    = 5'd2;
  localparam logic [IdxW-1:0] StUpDown    = 5'd3;
  localparam logic [IdxW-1:0] StMedRuns   = 5'd4;
  localparam logic [IdxW-1:0] StMedMax    = 5'd5;
  localparam logic [IdxW-1:0] StCollSum   = 5'd6;
  localparam logic [IdxW-1:0] StCollCnt   = 5'd7;
  localparam logic [IdxW-1:0] StCollMax   = 5'd8;
  localparam logic [IdxW-1:0] StPeriod0   = 5'd9;
  localparam logic [IdxW-1:0] StCov0      = 5'd14;

  // Enable mask bits that do not map one to one
  localparam int TstColl    = 6;
  localparam int TstCollMax = 7;
  localparam int TstPeriod0 = 8;
  localparam int TstCov0    = 13;

  typedef enum logic [1:0] {
    CfgBinary = 2'd0,
    CfgMean   = 2'd1,
    CfgMedian = 2'd2,
    CfgEnable = 2'd3
  } cfg_reg_e;

  typedef logic [NumStats-1:0][StatW-1:0] stat_set_t;

  typedef struct packed {
    logic            valid;
    logic            last;
    logic            take;
    logic            elem;
    logic [SymW-1:0] xs;
    logic [SymW-1:0] xc;
    logic [SymW-1:0] xk;
    logic [ExcW-1:0] exc_a;
    logic [ExcW-1:0] exc_acc;
    logic [CntW-1:0] mruns;
    logic [CntW-1:0] mmax;
  } fe_pipe_t;

endpackage

`default_nettype wire

// ===== rtl/ise_front.sv =====
// Sample stage: counts, running sums, median runs and binary bit grouping.
// Depends on ise_pkg; feeds at most one element request a cycle to ise_core.
`default_nettype none

module ise_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [ise_pkg::SymW-1:0] raw_symbol_i,
  input  logic [ise_pkg::SymW-1:0] mapped_symbol_i,
  input  logic                     last_symbol_i,
  input  logic                     binary_mode_i,
  input  logic [ise_pkg::MeanW-1:0] mean_q16_i,
  input  logic [ise_pkg::MedW-1:0] median_x2_i,
  output logic                     flush_busy_o,
  output ise_pkg::fe_pipe_t        pipe_o
);
  import ise_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d, sum_n;
  logic [ExcW-1:0] acc_q, acc_d, acc_n;
  logic [CntW-1:0] mruns_q, mruns_d, mruns_n;
  logic [CntW-1:0] mcur_q, mcur_d, mcur_n;
  logic [CntW-1:0] mmax_q, mmax_d, mmax_n;
  logic            prev_below_q, prev_below_d;
  logic [3:0]      pop_q, pop_d, pop_n, gpop;
  logic [SymW-1:0] packed_q, packed_d, packed_n, gpacked;
  logic [3:0]      pos_q, pos_d, pos_n, gpos;
  logic            fl_pend_q, fl_pend_d;
  fe_pipe_t        pipe_q, pipe_d;
  logic            take, below, bit_v, samp_elem, flush_now, two_elem;
  logic [SymW-1:0] s_xs, s_xc, s_xk;

  always_comb begin
    take  = cnt_q < CntW'(MaxSamples);
    sum_n = sum_q + SumW'(raw_symbol_i);
    acc_n = acc_q + ExcW'(mean_q16_i);
    below = binary_mode_i ? ~mapped_symbol_i[0] : ({mapped_symbol_i, 1'b0} < median_x2_i);

    if (cnt_q == '0) begin
      mruns_n = CntW'(1);
      mcur_n  = CntW'(1);
    end else if (below == prev_below_q) begin
      mruns_n = mruns_q;
      mcur_n  = mcur_q + CntW'(1);
    end else begin
      mruns_n = mruns_q + CntW'(1);
      mcur_n  = CntW'(1);
    end
    mmax_n = (mcur_n > mmax_q) ? mcur_n : mmax_q;

    // bit grouping, first bit lands in the MSB
    bit_v    = mapped_symbol_i[0];
    pop_n    = pop_q + 4'(bit_v);
    packed_n = packed_q | (SymW'(bit_v) << (3'd7 - pos_q[2:0]));
    pos_n    = pos_q + 4'd1;

    samp_elem = 1'b0;
    s_xs      = mapped_symbol_i;
    s_xc      = raw_symbol_i;
    s_xk      = mapped_symbol_i;
    gpop      = pop_q;
    gpacked   = packed_q;
    gpos      = pos_q;
    if (take && binary_mode_i) begin
      gpop    = pop_n;
      gpacked = packed_n;
      gpos    = pos_n;
      if (pos_n[3]) begin
        samp_elem = 1'b1;
        s_xs      = SymW'(pop_n);
        s_xc      = SymW'(pop_n);
        s_xk      = packed_n;
        gpop      = '0;
        gpacked   = '0;
        gpos      = '0;
      end
    end else if (take) begin
      samp_elem = 1'b1;
    end
    flush_now = last_symbol_i && (gpos != '0);
    // a partial group left from binary mode plus a symbol element: two elements
    two_elem  = flush_now && samp_elem;

    cnt_d        = cnt_q;
    sum_d        = sum_q;
    acc_d        = acc_q;
    mruns_d      = mruns_q;
    mcur_d       = mcur_q;
    mmax_d       = mmax_q;
    prev_below_d = prev_below_q;
    pop_d        = pop_q;
    packed_d     = packed_q;
    pos_d        = pos_q;
    fl_pend_d    = 1'b0;
    pipe_d       = pipe_q;
    pipe_d.valid = 1'b0;

    if (fl_pend_q) begin
      pipe_d.valid = 1'b1;
      pipe_d.last  = 1'b1;
      pipe_d.take  = 1'b0;
      pipe_d.elem  = 1'b1;
      pipe_d.xs    = SymW'(pop_q);
      pipe_d.xc    = SymW'(pop_q);
      pipe_d.xk    = packed_q;
      pop_d        = '0;
      packed_d     = '0;
      pos_d        = '0;
    end else if (accept_i) begin
      pipe_d.valid   = 1'b1;
      pipe_d.last    = last_symbol_i && !two_elem;
      pipe_d.take    = take;
      pipe_d.elem    = samp_elem || flush_now;
      pipe_d.xs      = samp_elem ? s_xs : SymW'(gpop);
      pipe_d.xc      = samp_elem ? s_xc : SymW'(gpop);
      pipe_d.xk      = samp_elem ? s_xk : gpacked;
      pipe_d.exc_a   = {sum_n, 16'b0};
      pipe_d.exc_acc = acc_n;
      if (take) begin
        cnt_d        = cnt_q + CntW'(1);
        sum_d        = sum_n;
        acc_d        = acc_n;
        mruns_d      = mruns_n;
        mcur_d       = mcur_n;
        mmax_d       = mmax_n;
        prev_below_d = below;
      end
      pop_d    = gpop;
      packed_d = gpacked;
      pos_d    = gpos;
      if (last_symbol_i) begin
        pipe_d.mruns = take ? mruns_n : mruns_q;
        pipe_d.mmax  = take ? mmax_n : mmax_q;
        cnt_d        = '0;
        sum_d        = '0;
        acc_d        = '0;
        mruns_d      = '0;
        mcur_d       = '0;
        mmax_d       = '0;
        prev_below_d = 1'b0;
        if (two_elem) begin
          fl_pend_d = 1'b1;
        end else begin
          pop_d    = '0;
          packed_d = '0;
          pos_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      sum_q        <= '0;
      acc_q        <= '0;
      mruns_q      <= '0;
      mcur_q       <= '0;
      mmax_q       <= '0;
      prev_below_q <= 1'b0;
      pop_q        <= '0;
      packed_q     <= '0;
      pos_q        <= '0;
      fl_pend_q    <= 1'b0;
      pipe_q       <= '0;
    end else begin
      cnt_q        <= cnt_d;
      sum_q        <= sum_d;
      acc_q        <= acc_d;
      mruns_q      <= mruns_d;
      mcur_q       <= mcur_d;
      mmax_q       <= mmax_d;
      prev_below_q <= prev_below_d;
      pop_q        <= pop_d;
      packed_q     <= packed_d;
      pos_q        <= pos_d;
      fl_pend_q    <= fl_pend_d;
      pipe_q       <= pipe_d;
    end
  end

  assign flush_busy_o = fl_pend_q;
  assign pipe_o       = pipe_q;

`ifndef SYNTHESIS
  a_flush_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_pend_q |=> !fl_pend_q && pipe_q.valid && pipe_q.last)
    else $error("partial group flush did not close the set");
`endif

endmodule

`default_nettype wire

// ===== rtl/ise_core.sv =====
// Element stage: excursion maximum, directional runs, collisions and lag statistics.
// Depends on ise_pkg; hands a finished statistic set to ise_emit.
`default_nettype none

module ise_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ise_pkg::fe_pipe_t pipe_i,
  output logic              push_o,
  output ise_pkg::stat_set_t snap_o
);
  import ise_pkg::*;

  logic [ExcW-1:0] exc_max_q, exc_max_d, exc_diff;
  logic [CntW-1:0] ecnt_q, ecnt_d;
  logic [SymW-1:0] prev_elem_q, prev_elem_d;
  logic            prev_up_q, prev_up_d, up;
  logic [CntW-1:0] druns_q, druns_d, dcur_q, dcur_d, dmax_q, dmax_d, ups_q, ups_d;
  logic [255:0]    seen_q, seen_d;
  logic [CntW-1:0] seg_q, seg_d, csum_q, csum_d, ccnt_q, ccnt_d, cmax_q, cmax_d, clen;
  logic [CntW-1:0] per_q [NumLags];
  logic [CntW-1:0] per_d [NumLags];
  logic [CovW-1:0] cov_q [NumLags];
  logic [CovW-1:0] cov_d [NumLags];
  logic [15:0]     prod  [NumLags];
  logic [SymW-1:0] sd_q  [MaxLag];
  logic [SymW-1:0] cd_q  [MaxLag];
  logic [CntW-1:0] altlen, downs, updown;
  logic            do_elem;

  always_comb begin
    do_elem = pipe_i.valid && pipe_i.elem;

    exc_diff  = (pipe_i.exc_a >= pipe_i.exc_acc) ? pipe_i.exc_a - pipe_i.exc_acc
                                                 : pipe_i.exc_acc - pipe_i.exc_a;
    exc_max_d = exc_max_q;
    if (pipe_i.valid && pipe_i.take && (exc_diff > exc_max_q)) exc_max_d = exc_diff;

    ecnt_d      = ecnt_q;
    prev_elem_d = prev_elem_q;
    prev_up_d   = prev_up_q;
    druns_d     = druns_q;
    dcur_d      = dcur_q;
    dmax_d      = dmax_q;
    ups_d       = ups_q;
    seen_d      = seen_q;
    seg_d       = seg_q;
    csum_d      = csum_q;
    ccnt_d      = ccnt_q;
    cmax_d      = cmax_q;
    up          = !(prev_elem_q > pipe_i.xs);
    clen        = seg_q + CntW'(1);
    for (int k = 0; k < NumLags; k++) begin
      per_d[k] = per_q[k];
      cov_d[k] = cov_q[k];
      prod[k]  = {8'b0, cd_q[LagW'(LagTab[k] - 1)]} * {8'b0, pipe_i.xc};
    end

    if (do_elem) begin
      if (ecnt_q != '0) begin
        if (ecnt_q == CntW'(1)) begin
          druns_d = CntW'(1);
          dcur_d  = CntW'(1);
        end else if (up == prev_up_q) begin
          dcur_d = dcur_q + CntW'(1);
        end else begin
          druns_d = druns_q + CntW'(1);
          dcur_d  = CntW'(1);
        end
        if (dcur_d > dmax_q) dmax_d = dcur_d;
        if (up) ups_d = ups_q + CntW'(1);
        prev_up_d = up;
      end
      prev_elem_d = pipe_i.xs;

      for (int k = 0; k < NumLags; k++) begin
        if (ecnt_q >= CntW'(LagTab[k])) begin
          if (sd_q[LagW'(LagTab[k] - 1)] == pipe_i.xs) per_d[k] = per_q[k] + CntW'(1);
          cov_d[k] = cov_q[k] + CovW'(prod[k]);
        end
      end

      if (seen_q[pipe_i.xk]) begin
        csum_d = csum_q + clen;
        ccnt_d = ccnt_q + CntW'(1);
        if (clen > cmax_q) cmax_d = clen;
        seen_d = '0;
        seg_d  = '0;
      end else begin
        seen_d[pipe_i.xk] = 1'b1;
        seg_d = seg_q + CntW'(1);
      end
      ecnt_d = ecnt_q + CntW'(1);
    end

    altlen = (ecnt_d == '0) ? '0 : ecnt_d - CntW'(1);
    downs  = altlen - ups_d;
    updown = (ups_d > downs) ? ups_d : downs;

    snap_o              = '0;
    snap_o[StExcursion] = StatW'(exc_max_d);
    snap_o[StDirRuns]   = StatW'(druns_d);
    snap_o[StDirMax]    = StatW'(dmax_d);
    snap_o[StUpDown]    = StatW'(updown);
    snap_o[StMedRuns]   = StatW'(pipe_i.mruns);
    snap_o[StMedMax]    = StatW'(pipe_i.mmax);
    snap_o[StCollSum]   = StatW'(csum_d);
    snap_o[StCollCnt]   = StatW'(ccnt_d);
    snap_o[StCollMax]   = StatW'(cmax_d);
    for (int k = 0; k < NumLags; k++) begin
      snap_o[StPeriod0 + IdxW'(k)] = StatW'(per_d[k]);
      snap_o[StCov0 + IdxW'(k)]    = StatW'(cov_d[k]);
    end

    push_o = pipe_i.valid && pipe_i.last;
    // close the set: clear everything but the delay lines
    if (push_o) begin
      exc_max_d   = '0;
      ecnt_d      = '0;
      prev_elem_d = '0;
      prev_up_d   = 1'b0;
      druns_d     = '0;
      dcur_d      = '0;
      dmax_d      = '0;
      ups_d       = '0;
      seen_d      = '0;
      seg_d       = '0;
      csum_d      = '0;
      ccnt_d      = '0;
      cmax_d      = '0;
      for (int k = 0; k < NumLags; k++) begin
        per_d[k] = '0;
        cov_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exc_max_q   <= '0;
      ecnt_q      <= '0;
      prev_elem_q <= '0;
      prev_up_q   <= 1'b0;
      druns_q     <= '0;
      dcur_q      <= '0;
      dmax_q      <= '0;
      ups_q       <= '0;
      seen_q      <= '0;
      seg_q       <= '0;
      csum_q      <= '0;
      ccnt_q      <= '0;
      cmax_q      <= '0;
      for (int k = 0; k < NumLags; k++) begin
        per_q[k] <= '0;
        cov_q[k] <= '0;
      end
    end else begin
      exc_max_q   <= exc_max_d;
      ecnt_q      <= ecnt_d;
      prev_elem_q <= prev_elem_d;
      prev_up_q   <= prev_up_d;
      druns_q     <= druns_d;
      dcur_q      <= dcur_d;
      dmax_q      <= dmax_d;
      ups_q       <= ups_d;
      seen_q      <= seen_d;
      seg_q       <= seg_d;
      csum_q      <= csum_d;
      ccnt_q      <= ccnt_d;
      cmax_q      <= cmax_d;
      for (int k = 0; k < NumLags; k++) begin
        per_q[k] <= per_d[k];
        cov_q[k] <= cov_d[k];
      end
    end
  end

  // delay lines: tap i holds the element i+1 places back
  always_ff @(posedge clk_i) begin
    if (do_elem) begin
      sd_q[0] <= pipe_i.xs;
      cd_q[0] <= pipe_i.xc;
      for (int i = 1; i < MaxLag; i++) begin
        sd_q[i] <= sd_q[i-1];
        cd_q[i] <= cd_q[i-1];
      end
    end
  end

`ifndef SYNTHESIS
  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (ecnt_q == '0) && (seg_q == '0) && (seen_q == '0))
    else $error("element state not cleared after set close");
`endif

endmodule

`default_nettype wire

// ===== rtl/ise_emit.sv =====
// Result queue: one pending statistic set, one set being sent, one result register.
// Depends on ise_pkg; drives the result ports of the top level.
`default_nettype none

module ise_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  ise_pkg::stat_set_t         snap_i,
  input  logic [ise_pkg::MaskW-1:0]  enable_mask_i,
  input  logic                       pop_i,
  output logic                       busy_o,
  output logic                       empty_o,
  output logic [ise_pkg::IdxW-1:0]   stat_index_o,
  output logic [ise_pkg::StatW-1:0]  stat_value_o,
  output logic                       last_result_o
);
  import ise_pkg::*;

  stat_set_t           pend_q, pend_d, work_q, work_d;
  logic                pend_v_q, pend_v_d;
  logic [NumStats-1:0] rem_q, rem_d, stat_en, sel_oh, rem_after;
  logic [IdxW-1:0]     sel;
  logic                out_v_q, out_v_d, out_last_q, out_last_d, out_free, load_out;
  logic [IdxW-1:0]     out_idx_q, out_idx_d;
  logic [StatW-1:0]    out_val_q, out_val_d;

  always_comb begin
    for (int i = 0; i < TstColl; i++) stat_en[i] = enable_mask_i[i];
    stat_en[StCollSum] = enable_mask_i[TstColl];
    stat_en[StCollCnt] = enable_mask_i[TstColl];
    stat_en[StCollMax] = enable_mask_i[TstCollMax];
    for (int k = 0; k < NumLags; k++) begin
      stat_en[StPeriod0 + IdxW'(k)] = enable_mask_i[TstPeriod0 + k];
      stat_en[StCov0 + IdxW'(k)]    = enable_mask_i[TstCov0 + k];
    end

    // lowest remaining index goes first
    sel = '0;
    for (int i = NumStats - 1; i >= 0; i--) begin
      if (rem_q[i]) sel = IdxW'(i);
    end
    sel_oh    = NumStats'(1) << sel;
    rem_after = rem_q & ~sel_oh;

    out_free = !out_v_q || pop_i;
    load_out = out_free && (rem_q != '0);

    rem_d      = rem_q;
    work_d     = work_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    out_idx_d  = out_idx_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;
    out_v_d    = out_v_q && !pop_i;

    if (load_out) begin
      out_v_d    = 1'b1;
      out_idx_d  = sel;
      out_val_d  = work_q[sel];
      out_last_d = (rem_after == '0);
      rem_d      = rem_after;
    end
    if ((rem_d == '0) && pend_v_q) begin
      work_d   = pend_q;
      rem_d    = stat_en;
      pend_v_d = 1'b0;
    end
    if (push_i) begin
      pend_d   = snap_i;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q   <= 1'b0;
      rem_q      <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      pend_v_q   <= pend_v_d;
      rem_q      <= rem_d;
      out_v_q    <= out_v_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    work_q    <= work_d;
    out_idx_q <= out_idx_d;
    out_val_q <= out_val_d;
  end

  assign busy_o        = pend_v_q;
  assign empty_o       = !out_v_q;
  assign stat_index_o  = out_idx_q;
  assign stat_value_o  = out_val_q;
  assign last_result_o = out_last_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !pend_v_q)
    else $error("statistic set pushed over a pending one");
  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && out_v_q && !out_last_q) |=> out_v_q && (out_idx_q > $past(out_idx_q)))
    else $error("results of a set out of index order");
`endif

endmodule

`default_nettype wire

// ===== rtl/iid_test_statistics_engine.sv =====
// Top level of the IID test statistics engine: configuration registers and
// the front, core and result stages. Depends on ise_pkg, ise_front, ise_core, ise_emit.
//
// Usage:
//   Input queue: drive raw_symbol_i, mapped_symbol_i, last_symbol_i with push;
//   a sample is taken at an edge with push high and full low. One sample per
//   cycle is sustained while full stays low. last_symbol_i closes the set.
//   Result queue: while empty is low the oldest result sits on stat_index_o,
//   stat_value_o and last_result_o; pop high takes it. One result per cycle
//   while pop stays high. A set's first result passes the front pipe
//   register, pending set, set being sent and result register, after any
//   leftover bit group flush. full is high while a closing sample or group
//   flush is in flight and while a finished set waits behind one still being
//   sent; a stalled receiver thus holds back input only after two sets.
//   Configuration: cfg_valid_i/cfg_ready_o write cfg_data_i into register
//   cfg_index_i (0 binary mode, 1 mean Q16, 2 twice the median, 3 enable
//   mask); cfg_ready_o is always high. Write only while the block is idle.
//   Reset: all statistics clear, enable mask all ones, other registers zero.
`default_nettype none

module iid_test_statistics_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [ise_pkg::SymW-1:0]  raw_symbol_i,
  input  logic [ise_pkg::SymW-1:0]  mapped_symbol_i,
  input  logic                      last_symbol_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [ise_pkg::IdxW-1:0]  stat_index_o,
  output logic [ise_pkg::StatW-1:0] stat_value_o,
  output logic                      last_result_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [ise_pkg::MeanW-1:0] cfg_data_i
);
  import ise_pkg::*;

  logic              binary_q;
  logic [MeanW-1:0]  mean_q;
  logic [MedW-1:0]   median_q;
  logic [MaskW-1:0]  mask_q;
  logic              accept, flush_busy, set_push, pend_busy;
  fe_pipe_t          pipe;
  stat_set_t         snap;

  assign cfg_ready_o = 1'b1;

  // hold configuration until rewritten
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binary_q <= 1'b0;
      mean_q   <= '0;
      median_q <= '0;
      mask_q   <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgBinary: binary_q <= cfg_data_i[0];
        CfgMean:   mean_q   <= cfg_data_i;
        CfgMedian: median_q <= cfg_data_i[MedW-1:0];
        CfgEnable: mask_q   <= cfg_data_i[MaskW-1:0];
      endcase
    end
  end

  // stall input while a closing request is in flight or the set buffer is taken
  assign full   = flush_busy || pend_busy || (pipe.valid && pipe.last);
  assign accept = push && !full;

  ise_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .raw_symbol_i    (raw_symbol_i),
    .mapped_symbol_i (mapped_symbol_i),
    .last_symbol_i   (last_symbol_i),
    .binary_mode_i   (binary_q),
    .mean_q16_i      (mean_q),
    .median_x2_i     (median_q),
    .flush_busy_o    (flush_busy),
    .pipe_o          (pipe)
  );

  ise_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pipe_i (pipe),
    .push_o (set_push),
    .snap_o (snap)
  );

  ise_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (set_push),
    .snap_i        (snap),
    .enable_mask_i (mask_q),
    .pop_i         (pop),
    .busy_o        (pend_busy),
    .empty_o       (empty),
    .stat_index_o  (stat_index_o),
    .stat_value_o  (stat_value_o),
    .last_result_o (last_result_o)
  );

endmodule

`default_nettype wire
